@@ hw/rtl/lms_pkg.sv @@
// Shared types and constants for the LED matrix grayscale scan block.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.

package lms_pkg;

	localparam int ROWS        = 8;
	localparam int COLUMNS     = 8;
	localparam int LEVEL_BITS  = 4;

	localparam int PAGE_PIXELS = ROWS * COLUMNS;
	localparam int STORE_DEPTH = 2 * PAGE_PIXELS;
	localparam int X_W         = $clog2(COLUMNS);
	localparam int Y_W         = $clog2(ROWS);
	localparam int SLOT_W      = X_W + Y_W;
	localparam int ADDR_W      = SLOT_W + 1;
	localparam int PIX_W       = 3 * LEVEL_BITS;
	localparam int COL_W       = 3 * COLUMNS;

	localparam int CMD_DEPTH   = 2;
	localparam int CFG_ADDR_W  = 3;

	// Request codes on the input channel.
	localparam logic [2:0] FUNC_SET_BACK   = 3'd0;
	localparam logic [2:0] FUNC_SET_FRONT  = 3'd1;
	localparam logic [2:0] FUNC_CLEAR_BACK = 3'd2;
	localparam logic [2:0] FUNC_SWAP       = 3'd3;
	localparam logic [2:0] FUNC_BLANK_BACK = 3'd4;
	localparam logic [2:0] FUNC_BLANK_ALL  = 3'd5;
	localparam logic [2:0] FUNC_TICK       = 3'd6;

	// Internal command codes after decode.
	localparam logic [2:0] OP_SET_BACK   = 3'd0;
	localparam logic [2:0] OP_SET_FRONT  = 3'd1;
	localparam logic [2:0] OP_SWAP       = 3'd2;
	localparam logic [2:0] OP_BLANK_BACK = 3'd3;
	localparam logic [2:0] OP_BLANK_ALL  = 3'd4;
	localparam logic [2:0] OP_TICK       = 3'd5;

	// Configuration register indexes (byte address bit 2).
	localparam logic REG_MIRROR_X = 1'b0;
	localparam logic REG_MIRROR_Y = 1'b1;

	typedef struct packed {
		logic [2:0]        op;
		logic [SLOT_W-1:0] slot;
		logic [PIX_W-1:0]  pix;   // green, red, blue nibbles, green on top
	} cmd_t;

endpackage

@@ hw/rtl/lms_if.sv @@
// Handshake channels for the LED matrix scan block: request input and scan result output.
// Depends on lms_pkg for the payload widths.

interface lms_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [2:0] px;
	logic [2:0] py;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, func, px, py, red, green, blue, input ready);
	modport sink (input valid, func, px, py, red, green, blue, output ready);
endinterface

interface lms_out_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 scan_row;
	logic [lms_pkg::COL_W-1:0]  column_bits;

	modport source (output valid, scan_row, column_bits, input ready);
	modport sink (input valid, scan_row, column_bits, output ready);
endinterface

@@ hw/rtl/lms_front.sv @@
// Front end: accepts requests, applies the mirror settings and turns them into commands.
// Depends on lms_pkg and lms_in_if.

module lms_front (
	lms_in_if.sink           in_ch,
	input  logic             mirror_x,
	input  logic             mirror_y,
	input  logic             push_ready,
	output logic             push,
	output lms_pkg::cmd_t    push_cmd
);

	logic [lms_pkg::X_W-1:0] x_map;
	logic [lms_pkg::Y_W-1:0] y_map;
	logic                    known;
	logic [lms_pkg::PIX_W-1:0] colors;

	assign in_ch.ready = push_ready;

	always_comb begin
		x_map = mirror_x ? lms_pkg::X_W'(lms_pkg::COLUMNS - 1) - in_ch.px : in_ch.px;
		// The row axis is flipped unless row mirroring is enabled.
		y_map = mirror_y ? in_ch.py : lms_pkg::Y_W'(lms_pkg::ROWS - 1) - in_ch.py;
		colors = {in_ch.green[7 -: lms_pkg::LEVEL_BITS], in_ch.red[7 -: lms_pkg::LEVEL_BITS],
			in_ch.blue[7 -: lms_pkg::LEVEL_BITS]};
	end

	always_comb begin
		known         = 1'b1;
		push_cmd.slot = {y_map, x_map};
		push_cmd.pix  = colors;
		push_cmd.op   = lms_pkg::OP_TICK;
		unique case (in_ch.func)
			lms_pkg::FUNC_SET_BACK: begin
				push_cmd.op = lms_pkg::OP_SET_BACK;
			end
			lms_pkg::FUNC_SET_FRONT: begin
				push_cmd.op = lms_pkg::OP_SET_FRONT;
			end
			lms_pkg::FUNC_CLEAR_BACK: begin
				push_cmd.op  = lms_pkg::OP_SET_BACK;
				push_cmd.pix = '0;
			end
			lms_pkg::FUNC_SWAP: begin
				push_cmd.op = lms_pkg::OP_SWAP;
			end
			lms_pkg::FUNC_BLANK_BACK: begin
				push_cmd.op = lms_pkg::OP_BLANK_BACK;
			end
			lms_pkg::FUNC_BLANK_ALL: begin
				push_cmd.op = lms_pkg::OP_BLANK_ALL;
			end
			lms_pkg::FUNC_TICK: begin
				push_cmd.op = lms_pkg::OP_TICK;
			end
			default: begin
				// Undefined request codes are accepted and dropped.
				known = 1'b0;
			end
		endcase
	end

	assign push = in_ch.valid && push_ready && known;

endmodule

@@ hw/rtl/lms_cmd_fifo.sv @@
// Two-entry command queue between the front end and the execution engine.
// Depends on lms_pkg for the command type and depth.

module lms_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lms_pkg::cmd_t push_cmd,
	output logic          push_ready,
	input  logic          pop,
	output logic          pop_valid,
	output lms_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = (lms_pkg::CMD_DEPTH > 1) ? $clog2(lms_pkg::CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(lms_pkg::CMD_DEPTH + 1);

	lms_pkg::cmd_t    entry_q [lms_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(lms_pkg::CMD_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lms_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lms_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ hw/rtl/lms_back.sv @@
// Execution engine: frame store memory, page state, row scan and the result register.
// Depends on lms_pkg and lms_out_if.

module lms_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  lms_pkg::cmd_t cmd,
	output logic          cmd_pop,
	lms_out_if.source     out_ch
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_TICK = 1'b1;
	localparam int   CNT_W   = lms_pkg::X_W + 1;
	localparam int   LVL_W   = lms_pkg::LEVEL_BITS;

	logic [lms_pkg::PIX_W-1:0]       store [lms_pkg::STORE_DEPTH];
	logic [lms_pkg::STORE_DEPTH-1:0] valid_q;

	logic                      state_q;
	logic                      front_q;
	logic [lms_pkg::Y_W-1:0]   row_q;
	logic [LVL_W-1:0]          level_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      rd_act_s1;
	logic                      rd_valid_s1;
	logic [lms_pkg::X_W-1:0]   rd_col_s1;
	logic [lms_pkg::PIX_W-1:0] rd_data_s1;
	logic [lms_pkg::COL_W-1:0] bits_q;
	logic                      out_valid_q;
	logic [lms_pkg::Y_W-1:0]   out_row_q;
	logic [lms_pkg::COL_W-1:0] out_bits_q;

	logic                        mem_we;
	logic [lms_pkg::ADDR_W-1:0]  mem_waddr;
	logic                        rd_issue;
	logic [lms_pkg::ADDR_W-1:0]  rd_addr;
	logic [lms_pkg::PIX_W-1:0]   pix;
	logic [LVL_W-1:0]            pix_g;
	logic [LVL_W-1:0]            pix_r;
	logic [LVL_W-1:0]            pix_b;
	logic [lms_pkg::COLUMNS-1:0] col_mask;
	logic [lms_pkg::COL_W-1:0]   hit_bits;
	logic                        last_col;

	// A tick only starts once the previous result has been taken.
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid
		&& ((cmd.op != lms_pkg::OP_TICK) || !out_valid_q);
	assign mem_we = cmd_pop
		&& ((cmd.op == lms_pkg::OP_SET_BACK) || (cmd.op == lms_pkg::OP_SET_FRONT));
	assign mem_waddr = {(cmd.op == lms_pkg::OP_SET_FRONT) ? front_q : ~front_q, cmd.slot};

	assign rd_issue = (state_q == ST_TICK) && !cnt_q[CNT_W-1];
	assign rd_addr  = {front_q, row_q, cnt_q[lms_pkg::X_W-1:0]};

	// Entries never written since the last blank read as zero.
	assign pix   = rd_valid_s1 ? rd_data_s1 : '0;
	assign pix_g = pix[3*LVL_W-1 -: LVL_W];
	assign pix_r = pix[2*LVL_W-1 -: LVL_W];
	assign pix_b = pix[LVL_W-1 -: LVL_W];

	assign col_mask = {1'b1, {(lms_pkg::COLUMNS-1){1'b0}}} >> rd_col_s1;
	assign hit_bits = {(pix_g > level_q) ? col_mask : '0,
		(pix_r > level_q) ? col_mask : '0,
		(pix_b > level_q) ? col_mask : '0};
	assign last_col = rd_act_s1 && (rd_col_s1 == lms_pkg::X_W'(lms_pkg::COLUMNS - 1));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_waddr] <= cmd.pix;
		end
		if (rd_issue) begin
			rd_data_s1 <= store[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= 1'b0;
			row_q       <= '0;
			level_q     <= '0;
			cnt_q       <= '0;
			valid_q     <= '0;
			rd_act_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				unique case (cmd.op)
					lms_pkg::OP_SET_BACK, lms_pkg::OP_SET_FRONT: begin
						valid_q[mem_waddr] <= 1'b1;
					end
					lms_pkg::OP_SWAP: begin
						front_q <= ~front_q;
					end
					lms_pkg::OP_BLANK_BACK: begin
						valid_q[{~front_q, {lms_pkg::SLOT_W{1'b0}}} +: lms_pkg::PAGE_PIXELS] <= '0;
					end
					lms_pkg::OP_BLANK_ALL: begin
						valid_q <= '0;
					end
					lms_pkg::OP_TICK: begin
						state_q <= ST_TICK;
						cnt_q   <= '0;
					end
					default: begin
					end
				endcase
			end
			if (rd_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_act_s1 <= rd_issue;
			if (last_col) begin
				state_q     <= ST_IDLE;
				out_valid_q <= 1'b1;
				if (row_q == lms_pkg::Y_W'(lms_pkg::ROWS - 1)) begin
					row_q   <= '0;
					level_q <= level_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_valid_s1 <= valid_q[rd_addr];
		rd_col_s1   <= cnt_q[lms_pkg::X_W-1:0];
		if (cmd_pop && (cmd.op == lms_pkg::OP_TICK)) begin
			bits_q <= '0;
		end else if (rd_act_s1) begin
			bits_q <= bits_q | hit_bits;
		end
		if (last_col) begin
			out_row_q  <= row_q;
			out_bits_q <= bits_q | hit_bits;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.scan_row    = out_row_q;
	assign out_ch.column_bits = out_bits_q;

	// The last pixel of a row arrives only after every read of that row was issued.
	a_last_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		last_col |-> (state_q == ST_TICK) && (cnt_q == CNT_W'(lms_pkg::COLUMNS)))
		else $error("row scan finished before all column reads were issued");

	// No result may be waiting while a row scan is running.
	a_no_result_during_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |-> !out_valid_q)
		else $error("result register busy during a row scan");

	a_blank_all_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && (cmd.op == lms_pkg::OP_BLANK_ALL)) |=> (valid_q == '0))
		else $error("blank of both pages left written entries");

	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_TICK))
		else $error("result raised outside a row scan");

endmodule

@@ hw/rtl/led_matrix_grayscale_scan.sv @@
// Double-buffered 8x8 RGB frame store with row-scan grayscale PWM output.
// Requests enter on in_ch (valid/ready); each tick request yields one result on out_ch
// (scan_row, column_bits from bit 23 down: green columns 0..7, red, blue).
// Pixel writes keep the top nibble of each color and apply the mirror registers,
// which sit on the APB port: mirror_x at address 0, mirror_y at address 4.
// A front end decodes and mirrors requests into a two-entry command queue; the back
// end executes them one at a time. A tick reads the eight pixels of its row from the
// frame store one per cycle, compares each color with the PWM level and collects the
// row's column bits in the result register. Other requests are taken one per cycle
// while no row scan is running; a new tick waits until the previous result is taken.
// Blanking a page clears its 64 written-entry flags together, not one by one.
// The input keeps accepting while a result waits: up to two requests queue up.
// When the receiver stalls, the result holds on out_ch and the next tick waits in
// the queue until the result is taken.
// Reset (arst_n low) clears both pages, the page select, the row, the PWM level
// and the mirror registers; in_ch is ready as soon as reset is released.

module led_matrix_grayscale_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	lms_in_if.sink                         in_ch,
	lms_out_if.source                      out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lms_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	logic          mirror_x_q;
	logic          mirror_y_q;
	logic          cfg_write;
	logic          push;
	logic          push_ready;
	lms_pkg::cmd_t push_cmd;
	logic          pop;
	logic          pop_valid;
	lms_pkg::cmd_t pop_cmd;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_x_q <= 1'b0;
			mirror_y_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				lms_pkg::REG_MIRROR_X: mirror_x_q <= pwdata[0];
				lms_pkg::REG_MIRROR_Y: mirror_y_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			lms_pkg::REG_MIRROR_X: prdata[0] = mirror_x_q;
			lms_pkg::REG_MIRROR_Y: prdata[0] = mirror_y_q;
			default: prdata = '0;
		endcase
	end

	lms_front u_front (
		.in_ch      (in_ch),
		.mirror_x   (mirror_x_q),
		.mirror_y   (mirror_y_q),
		.push_ready (push_ready),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	lms_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd)
	);

	lms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_pop   (pop),
		.out_ch    (out_ch)
	);

endmodule
